@@ hw/rtl/cq_pkg.sv @@
// Shared types, action and status codes for the circular queue.
package cq_pkg;

   localparam int DATA_W        = 32;
   localparam int CQ_DEPTH_DEF  = 8;
   localparam int CMD_Q_DEPTH   = 2;

   // Action codes on the request channel
   localparam logic [1:0] ACT_INSERT  = 2'd0;
   localparam logic [1:0] ACT_DELETE  = 2'd1;
   localparam logic [1:0] ACT_DISPLAY = 2'd2;

   // Status codes on the response channel
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Command handed from the front end to the back end
   typedef struct packed {
      logic [1:0]               action;
      logic signed [DATA_W-1:0] value;
   } cmd_type;

   // Back end controller states
   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } back_state_type;

endpackage

@@ hw/rtl/cq_front.sv @@
// Front end: accepts request transactions, drops unknown actions, queues commands.
module cq_front import cq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_action,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     cmd_valid,
   input  logic                     cmd_ready,
   output cmd_type                  cmd
);

   localparam int QPTR_W = (CMD_Q_DEPTH > 1) ? $clog2(CMD_Q_DEPTH) : 1;
   localparam int QCNT_W = $clog2(CMD_Q_DEPTH + 1);

   cmd_type             q_ff [CMD_Q_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;
   logic                known;
   logic                push;
   logic                pop;

   // Classify the action: code three is dropped without a response
   always_comb begin
      unique case (req_action)
         ACT_INSERT, ACT_DELETE, ACT_DISPLAY: known = 1'b1;
         default:                             known = 1'b0;
      endcase
   end

   assign req_ready = (fill_ff != QCNT_W'(CMD_Q_DEPTH));
   assign push      = req_valid && req_ready && known;
   assign cmd_valid = (fill_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(CMD_Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(CMD_Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      fill_in = fill_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the queued command
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{action: req_action, value: req_value};
      end
   end

endmodule

@@ hw/rtl/cq_back.sv @@
// Back end: ring storage, head/tail/count and the response sequencer.
module cq_back import cq_pkg::*; #(
   parameter int DEPTH = CQ_DEPTH_DEF,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   output logic                     cmd_ready,
   input  cmd_type                  cmd,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic                     rsp_last,
   output logic [CNT_W-1:0]         stat_count
);

   localparam int IDX_W = $clog2(DEPTH);

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   logic [DATA_W-1:0]        mem [DEPTH];
   logic [DATA_W-1:0]        rd_data_ff;
   back_state_type           state_ff, state_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]         rd_left_ff, rd_left_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     out_free;
   logic                     wr_en;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic                     is_full;
   logic                     is_empty;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   // Execute commands and sequence responses
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      rd_left_in    = rd_left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      cmd_ready     = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      unique case (state_ff)
         S_IDLE: begin
            cmd_ready = out_free;
            if (cmd_valid && out_free) begin
               case (cmd.action)
                  ACT_INSERT: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '0;
                     rsp_last_in  = 1'b1;
                     if (is_full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_OK;
                        wr_en         = 1'b1;
                        tail_in       = ring_next(tail_ff);
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  default: begin
                     // Delete and display both start with a read at the head
                     if (is_empty) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                        rsp_data_in   = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        rd_en     = 1'b1;
                        state_in  = S_READ;
                        rd_idx_in = ring_next(head_ff);
                        if (cmd.action == ACT_DELETE) begin
                           rd_left_in = CNT_W'(1);
                           head_in    = ring_next(head_ff);
                           count_in   = count_ff - 1'b1;
                        end else begin
                           rd_left_in = count_ff;
                        end
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            rd_addr = rd_idx_ff;
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_data_in   = rd_data_ff;
               rsp_last_in   = (rd_left_ff == CNT_W'(1));
               if (rd_left_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en      = 1'b1;
                  rd_idx_in  = ring_next(rd_idx_ff);
                  rd_left_in = rd_left_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rd_left_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rd_left_ff   <= rd_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload of the response register and the read cursor
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Ring storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[tail_ff] <= cmd.value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_last   = rsp_last_ff;
   assign stat_count = count_ff;

endmodule

@@ hw/rtl/circular_queue_top.sv @@
// Top level of the circular queue: front end, command queue and back end.
//
// Request channel (req_valid/req_ready, req_action, req_value) carries one
// action per transaction: insert, delete or display. Action code three is
// accepted and dropped with no response. Response channel (rsp_valid/
// rsp_ready, rsp_status, rsp_data, rsp_last) carries one transaction per
// result; rsp_last marks the final result of a request.
// A two-entry command queue sits behind the request port, so requests are
// taken while a response waits in the output register.
// Insert and full or empty responses pass through the command queue and then
// the response register; delete and display also pass through the single
// registered read port of the ring storage, one entry per read, and the back
// end takes no new command until the last result is in the response register.
// Reset empties the queue (head, tail and count to zero) and drops any
// queued command or pending response; storage contents are not cleared.
// When rsp_ready is low the response register holds and the back end stops;
// the command queue then fills and req_ready falls.
module circular_queue_top import cq_pkg::*; #(
   parameter int DEPTH = CQ_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_action,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_data,
   output logic                     rsp_last
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic             cmd_valid;
   logic             cmd_ready;
   cmd_type          cmd;
   logic [CNT_W-1:0] stat_count;

   cq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_value  (req_value),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   cq_back #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last),
      .stat_count (stat_count)
   );

   // Entry count never exceeds capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat_count <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   // A full response is only given while the queue holds DEPTH entries
   a_full_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> stat_count == CNT_W'(DEPTH))
      else $error("full response with queue not full");

   // An empty response is only given while the queue is empty
   a_empty_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_EMPTY) |-> stat_count == '0)
      else $error("empty response with entries held");

   // Error responses are single results with zero data
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_last && (rsp_data == '0))
      else $error("error response malformed");

endmodule

@@ tb/circular_queue_checker.sv @@
// Scoreboard for the circular queue: predicts responses from accepted requests and checks them.
`timescale 1ns / 100ps

module circular_queue_checker import cq_pkg::*; #(
   parameter int DEPTH = CQ_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [1:0]               req_action,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [1:0]               rsp_status,
   input  logic signed [DATA_W-1:0] rsp_data,
   input  logic                     rsp_last,
   output int                       error_count,
   output int                       pending_count
);

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] data;
      logic                     last;
   } queue_rsp_type;

   // Shadow copy of the ring and its pointers
   logic signed [DATA_W-1:0] ring_mem [DEPTH];
   int                       rd_ptr;
   int                       wr_ptr;
   int                       fill_level;

   // Responses owed by the block, oldest first
   queue_rsp_type            owed_rsp_q [$];
   queue_rsp_type            seen_rsp;
   queue_rsp_type            due_rsp;

   function automatic queue_rsp_type make_rsp(logic [1:0] st, logic signed [DATA_W-1:0] word,
                                              logic lst);
      queue_rsp_type r;
      r.status = st;
      r.data   = word;
      r.last   = lst;
      return r;
   endfunction

   // Apply one request to the shadow ring and queue up the responses it causes
   function automatic void apply_request(logic [1:0] act, logic signed [DATA_W-1:0] word);
      int idx;
      int n;
      case (act)
         ACT_INSERT: begin
            if (fill_level == DEPTH) begin
               owed_rsp_q.push_back(make_rsp(ST_FULL, '0, 1'b1));
            end else begin
               ring_mem[wr_ptr] = word;
               wr_ptr           = (wr_ptr + 1) % DEPTH;
               fill_level++;
               owed_rsp_q.push_back(make_rsp(ST_OK, '0, 1'b1));
            end
         end
         ACT_DELETE: begin
            if (fill_level == 0) begin
               owed_rsp_q.push_back(make_rsp(ST_EMPTY, '0, 1'b1));
            end else begin
               owed_rsp_q.push_back(make_rsp(ST_OK, ring_mem[rd_ptr], 1'b1));
               rd_ptr = (rd_ptr + 1) % DEPTH;
               fill_level--;
            end
         end
         ACT_DISPLAY: begin
            if (fill_level == 0) begin
               owed_rsp_q.push_back(make_rsp(ST_EMPTY, '0, 1'b1));
            end else begin
               // walk head to tail without moving the pointers
               idx = rd_ptr;
               for (n = 0; n < fill_level; n++) begin
                  owed_rsp_q.push_back(make_rsp(ST_OK, ring_mem[idx], n == fill_level - 1));
                  idx = (idx + 1) % DEPTH;
               end
            end
         end
         default: begin
            // unused action code: dropped, no response
         end
      endcase
   endfunction

   // Predict on each request transaction, compare on each response transaction
   always @(posedge clock) begin
      if (reset) begin
         rd_ptr     = 0;
         wr_ptr     = 0;
         fill_level = 0;
         owed_rsp_q.delete();
         error_count = 0;
      end else begin
         if (req_valid && req_ready) apply_request(req_action, req_value);
         if (rsp_valid && rsp_ready) begin
            seen_rsp = make_rsp(rsp_status, rsp_data, rsp_last);
            if (owed_rsp_q.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: unexpected response status=%0d data=%0d last=%0b",
                           $time, seen_rsp.status, seen_rsp.data, seen_rsp.last);
               error_count++;
            end else begin
               due_rsp = owed_rsp_q.pop_front();
               if (seen_rsp.status !== due_rsp.status || seen_rsp.data !== due_rsp.data ||
                   seen_rsp.last !== due_rsp.last) begin
                  if (error_count < 10)
                     $display("%0t: mismatch expected status=%0d data=%0d last=%0b,",
                              $time, due_rsp.status, due_rsp.data, due_rsp.last,
                              " got status=%0d data=%0d last=%0b",
                              seen_rsp.status, seen_rsp.data, seen_rsp.last);
                  error_count++;
               end
            end
         end
      end
      pending_count = owed_rsp_q.size();
   end

endmodule

@@ tb/circular_queue_top_test.sv @@
// Testbench top for the circular queue: clock, reset, request stimulus, response stalls, verdict.
`timescale 1ns / 100ps

module circular_queue_top_test;
   import cq_pkg::*;

   localparam int         DEPTH        = CQ_DEPTH_DEF;
   localparam int         RANDOM_ITEMS = 440;
   localparam int         CYCLE_LIMIT  = 800000;
   localparam logic [1:0] ACT_UNUSED   = 2'd3;

   typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_HOLD} rx_mode_type;
   typedef enum int {BIAS_FILL, BIAS_DRAIN, BIAS_MIX} fill_bias_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [1:0]               req_action;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_data;
   logic                     rsp_last;

   int                       error_count;
   int                       pending_count;
   int                       cycle_count = 0;
   int                       burst_left;
   rx_mode_type              rx_mode;
   int                       rx_left;

   circular_queue_top #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data),
      .rsp_last   (rsp_last)
   );

   circular_queue_checker #(.DEPTH(DEPTH)) rsp_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_data      (rsp_data),
      .rsp_last      (rsp_last),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Stall the response channel in stretches of varying pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_mode   <= RX_OPEN;
         rx_left   <= 0;
      end else begin
         if (rx_left == 0) begin
            rx_mode <= rx_mode_type'($urandom_range(0, 3));
            rx_left <= $urandom_range(4, 40);
         end else begin
            rx_left <= rx_left - 1;
         end
         case (rx_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ready <= 1'b0;
         endcase
      end
   end

   // Drive one request transaction, then idle for a while at the end of a burst
   task automatic send_request(input logic [1:0] act, input logic signed [DATA_W-1:0] word);
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= word;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end
   endtask

   initial begin
      int            sent_items;
      int            seg_left;
      fill_bias_type seg_bias;
      int            ins_pct;
      int            del_pct;
      int            roll;
      logic [1:0]    act;
      logic signed [DATA_W-1:0] word;

      sent_items  = 0;
      seg_left    = 0;
      seg_bias    = BIAS_MIX;
      burst_left  = $urandom_range(1, 12);
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_action <= ACT_INSERT;
      req_value  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty queue, unused code, fill with edge words, full, wrap
      send_request(ACT_DISPLAY, '0);
      send_request(ACT_DELETE, '0);
      send_request(ACT_UNUSED, 32'sh7FFFFFFF);
      send_request(ACT_INSERT, 32'sh80000000);
      send_request(ACT_INSERT, 32'sh7FFFFFFF);
      send_request(ACT_INSERT, 32'sh00000000);
      send_request(ACT_INSERT, 32'shFFFFFFFF);
      send_request(ACT_INSERT, 32'sh55555555);
      send_request(ACT_INSERT, 32'shAAAAAAAA);
      send_request(ACT_INSERT, 32'sh00000001);
      send_request(ACT_INSERT, 32'sh12345678);
      send_request(ACT_INSERT, 32'sh0BADF00D);
      send_request(ACT_DISPLAY, '0);
      send_request(ACT_DELETE, 32'shFFFFFFFF);
      send_request(ACT_DELETE, '0);
      send_request(ACT_DELETE, '0);
      send_request(ACT_INSERT, 32'sh7FFF0001);
      send_request(ACT_INSERT, 32'sh8000FFFE);
      send_request(ACT_DISPLAY, 32'sh80000000);
      send_request(ACT_UNUSED, '0);

      // Random: segments that lean toward filling, draining or neither
      while (sent_items < RANDOM_ITEMS) begin
         if (seg_left == 0) begin
            seg_bias = fill_bias_type'($urandom_range(0, 2));
            seg_left = $urandom_range(8, 40);
         end
         seg_left--;
         ins_pct = (seg_bias == BIAS_FILL) ? 70 : (seg_bias == BIAS_DRAIN) ? 15 : 42;
         del_pct = (seg_bias == BIAS_FILL) ? 15 : (seg_bias == BIAS_DRAIN) ? 70 : 42;
         roll    = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 3) act = ACT_UNUSED;
         else if (roll < ins_pct) act = ACT_INSERT;
         else if (roll < ins_pct + del_pct) act = ACT_DELETE;
         else act = ACT_DISPLAY;
         case ($urandom_range(0, 9))
            0:       word = 32'sh80000000;
            1:       word = 32'sh7FFFFFFF;
            2:       word = '0;
            3:       word = -1;
            default: word = $urandom;
         endcase
         send_request(act, word);
         if (act != ACT_UNUSED) sent_items++;
      end

      // Drain and settle
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
